// ===== rtl/core/tli_pkg.sv =====
// shared widths, codes, types and rounding helpers for the trilinear interpolator
`default_nettype none

package tli_pkg;

  // number format
  localparam int VALUE_W  = 32;
  localparam int FRAC_W   = 16;
  localparam int CFG_W    = 32;

  // structure of one interpolation
  localparam int NUM_AXES    = 3;
  localparam int NUM_PAIRS   = 4;
  localparam int NUM_CORNERS = 8;

  // multiplier operand b carries an unsigned register or a signed weight
  localparam int MUL_B_W = ((VALUE_W > CFG_W) ? VALUE_W : CFG_W) + 1;
  localparam int PROD_W  = VALUE_W + MUL_B_W;
  localparam int GUARD_W = $clog2(NUM_CORNERS);
  localparam int ACC_W   = PROD_W + GUARD_W;

  // cycles from an accepted start to its done strobe
  localparam int PIPE_DEPTH = 12;

  // corners and z weights wait until the pair weights are ready
  localparam int CORNER_DLY = 5;
  localparam int Z_DLY      = 2;

  // register indexes
  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_INV_X = 2'd0;
  localparam logic [IDX_W-1:0] REG_INV_Y = 2'd1;
  localparam logic [IDX_W-1:0] REG_INV_Z = 2'd2;

  // constants
  localparam logic [CFG_W-1:0]         INV_RESET = CFG_W'(1) << FRAC_W;
  localparam logic signed [VALUE_W+1:0] ONE_EXT  = (VALUE_W+2)'(1) << FRAC_W;
  localparam logic signed [ACC_W-1:0]   RND_HALF = ACC_W'(1) << (FRAC_W - 1);
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // corner order 000, 001, 010, 100, 011, 101, 110, 111
  // pair products: 0 = left x left y, 1 = left x right y, 2 = right x left y, 3 = right right
  localparam int unsigned LANE_PAIR [NUM_CORNERS] = '{0, 0, 1, 2, 1, 2, 3, 3};
  // bit k set where corner k takes the right-hand z weight
  localparam logic [NUM_CORNERS-1:0] LANE_Z_RIGHT = 8'b1011_0010;

  // a saturated value and its clip flag
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      clip;
  } fx_t;

  // both weights of one axis
  typedef struct packed {
    logic signed [VALUE_W-1:0] left;
    logic signed [VALUE_W-1:0] right;
    logic                      clip;
  } axis_w_t;

  // sign extend a product to accumulator width
  function automatic logic signed [ACC_W-1:0] ext_prod(input logic signed [PROD_W-1:0] p);
    return {{GUARD_W{p[PROD_W-1]}}, p};
  endfunction

  // round half up, drop fraction bits, clip to value width
  function automatic fx_t rnd_sat(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0]   sum;
    logic signed [ACC_W-1:0]   shifted;
    logic [ACC_W-VALUE_W:0]    top;
    fx_t                       res;
    sum     = x + RND_HALF;
    shifted = sum >>> FRAC_W;
    top     = shifted[ACC_W-1:VALUE_W-1];
    if ((&top) || (~|top)) begin
      res.value = shifted[VALUE_W-1:0];
      res.clip  = 1'b0;
    end else begin
      res.value = shifted[ACC_W-1] ? VALUE_MIN : VALUE_MAX;
      res.clip  = 1'b1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tli_fx_mul.sv =====
// fixed point multiply with rounding and saturation, two register stages
`default_nettype none

module tli_fx_mul
  import tli_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic signed [VALUE_W-1:0] a,
  input  wire logic signed [MUL_B_W-1:0] b,
  input  wire logic                      clip_in,
  output fx_t                            res
);

  logic signed [PROD_W-1:0] prod;
  logic                     clip_q;
  fx_t                      rs;

  // full product
  always_ff @(posedge clk) begin
    prod   <= a * b;
    clip_q <= clip_in;
  end

  // round and clip
  always_comb begin
    rs = rnd_sat(ext_prod(prod));
  end

  always_ff @(posedge clk) begin
    res.value <= rs.value;
    res.clip  <= rs.clip | clip_q;
  end

endmodule

`default_nettype wire

// ===== rtl/core/tli_axis_weight.sv =====
// one axis: scales the offset to the right-hand weight and forms its complement
`default_nettype none

module tli_axis_weight
  import tli_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic signed [VALUE_W-1:0] offset,
  input  wire logic [CFG_W-1:0]          inv,
  output axis_w_t                        w
);

  fx_t                       wr;
  logic signed [VALUE_W+1:0] diff;
  logic [2:0]                top;
  logic signed [VALUE_W-1:0] left;
  logic                      left_clip;

  // right-hand weight: offset times reciprocal spacing
  tli_fx_mul u_scale (
    .clk     (clk),
    .a       (offset),
    .b       (MUL_B_W'(inv)),
    .clip_in (1'b0),
    .res     (wr)
  );

  // left-hand weight: one minus right, clipped
  always_comb begin
    diff = ONE_EXT - {{2{wr.value[VALUE_W-1]}}, wr.value};
    top  = diff[VALUE_W+1:VALUE_W-1];
    if ((&top) || (~|top)) begin
      left      = diff[VALUE_W-1:0];
      left_clip = 1'b0;
    end else begin
      left      = diff[VALUE_W+1] ? VALUE_MIN : VALUE_MAX;
      left_clip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    w.left  <= left;
    w.right <= wr.value;
    w.clip  <= wr.clip | left_clip;
  end

endmodule

`default_nettype wire

// ===== rtl/core/tli_corner_lane.sv =====
// one corner: triple weight, then corner value times weight
`default_nettype none

module tli_corner_lane
  import tli_pkg::*;
(
  input  wire logic                      clk,
  input  wire fx_t                       pxy,
  input  wire logic signed [VALUE_W-1:0] w_z,
  input  wire logic signed [VALUE_W-1:0] corner,
  output logic signed [PROD_W-1:0]       prod,
  output logic                           clip
);

  fx_t                       wt;
  logic signed [VALUE_W-1:0] corner_d1;
  logic signed [VALUE_W-1:0] corner_d2;

  // pair product times z weight
  tli_fx_mul u_weight (
    .clk     (clk),
    .a       (pxy.value),
    .b       (MUL_B_W'(w_z)),
    .clip_in (pxy.clip),
    .res     (wt)
  );

  // corner value waits for its weight
  always_ff @(posedge clk) begin
    corner_d1 <= corner;
    corner_d2 <= corner_d1;
  end

  // weighted corner, kept at full precision
  always_ff @(posedge clk) begin
    prod <= corner_d2 * wt.value;
    clip <= wt.clip;
  end

endmodule

`default_nettype wire

// ===== rtl/core/tli_merge.sv =====
// registered adder tree over the lane products, then final round and clip
`default_nettype none

module tli_merge
  import tli_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [PROD_W-1:0] prod [NUM_CORNERS],
  input  wire logic [NUM_CORNERS-1:0]   clip,
  output fx_t                           result
);

  logic signed [ACC_W-1:0] sum4 [NUM_PAIRS];
  logic signed [ACC_W-1:0] sum2 [2];
  logic signed [ACC_W-1:0] total;
  logic                    clip4;
  logic                    clip2;
  logic                    clip_t;
  fx_t                     rs;

  // first level: neighbouring lanes
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_PAIRS; i++) begin
      sum4[i] <= ext_prod(prod[2*i]) + ext_prod(prod[2*i+1]);
    end
    clip4 <= |clip;
  end

  // second and third levels
  always_ff @(posedge clk) begin
    for (int j = 0; j < 2; j++) begin
      sum2[j] <= sum4[2*j] + sum4[2*j+1];
    end
    clip2  <= clip4;
    total  <= sum2[0] + sum2[1];
    clip_t <= clip2;
  end

  // round and clip the sum
  always_comb begin
    rs = rnd_sat(total);
  end

  always_ff @(posedge clk) begin
    result.value <= rs.value;
    result.clip  <= rs.clip | clip_t;
  end

endmodule

`default_nettype wire

// ===== rtl/core/trilinear_interpolator_core.sv =====
// top level of the trilinear interpolator: registers, lanes and merge
`default_nettype none

// Trilinear interpolator. Each transfer on start (start high, busy low) takes the eight
// corner values of one grid cell and the point's offset within it, all signed Q16.16,
// and at the pipeline's end done is high for one cycle with interpolated_value and
// saturated. A new transfer may follow in every cycle while busy is low, so the block
// sustains one point per clock; the latency is set by the chain of three fixed point
// multiplies (axis weight, pair weight, triple weight) of two stages each, one stage for
// the left-hand weight, a one stage corner multiply, a three level adder tree and a
// final rounding stage. There is no backpressure: results must be taken in the
// cycle done is high. busy is high during reset and the cycle after. The reciprocal
// spacings are written through wr_en, wr_index and wr_data, should be changed only when
// no point is in flight, and reset to 1.0.
module trilinear_interpolator_core
  import tli_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  output logic                           done,
  input  wire logic                      wr_en,
  input  wire logic [IDX_W-1:0]          wr_index,
  input  wire logic [CFG_W-1:0]          wr_data,
  input  wire logic signed [VALUE_W-1:0] corner_000,
  input  wire logic signed [VALUE_W-1:0] corner_001,
  input  wire logic signed [VALUE_W-1:0] corner_010,
  input  wire logic signed [VALUE_W-1:0] corner_100,
  input  wire logic signed [VALUE_W-1:0] corner_011,
  input  wire logic signed [VALUE_W-1:0] corner_101,
  input  wire logic signed [VALUE_W-1:0] corner_110,
  input  wire logic signed [VALUE_W-1:0] corner_111,
  input  wire logic signed [VALUE_W-1:0] offset_x,
  input  wire logic signed [VALUE_W-1:0] offset_y,
  input  wire logic signed [VALUE_W-1:0] offset_z,
  output logic signed [VALUE_W-1:0]      interpolated_value,
  output logic                           saturated
);

  logic                      settle;
  logic                      accept;
  logic [PIPE_DEPTH-1:0]     vld;
  logic [CFG_W-1:0]          inv_x;
  logic [CFG_W-1:0]          inv_y;
  logic [CFG_W-1:0]          inv_z;
  logic [CFG_W-1:0]          inv_arr    [NUM_AXES];
  logic signed [VALUE_W-1:0] offset_arr [NUM_AXES];
  logic signed [VALUE_W-1:0] corner_in  [NUM_CORNERS];
  logic signed [VALUE_W-1:0] c_dly      [CORNER_DLY][NUM_CORNERS];
  axis_w_t                   aw         [NUM_AXES];
  axis_w_t                   z_dly      [Z_DLY];
  logic                      axis_clip;
  fx_t                       pxy        [NUM_PAIRS];
  logic signed [PROD_W-1:0]  lane_prod  [NUM_CORNERS];
  logic [NUM_CORNERS-1:0]    lane_clip;
  fx_t                       result;

  // busy during reset and in the cycle after it
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= 1'b1;
    end else begin
      settle <= 1'b0;
    end
  end

  assign busy   = rst | settle;
  assign accept = start & ~busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_x <= INV_RESET;
      inv_y <= INV_RESET;
      inv_z <= INV_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_INV_X: inv_x <= wr_data;
        REG_INV_Y: inv_y <= wr_data;
        REG_INV_Z: inv_z <= wr_data;
        default:   ;
      endcase
    end
  end

  // valid tracking along the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], accept};
    end
  end

  assign done = vld[PIPE_DEPTH-1];

  // input gathering
  assign inv_arr    = '{inv_x, inv_y, inv_z};
  assign offset_arr = '{offset_x, offset_y, offset_z};
  assign corner_in  = '{corner_000, corner_001, corner_010, corner_100,
                        corner_011, corner_101, corner_110, corner_111};

  // corner delay line
  always_ff @(posedge clk) begin
    c_dly[0] <= corner_in;
    for (int k = 1; k < CORNER_DLY; k++) begin
      c_dly[k] <= c_dly[k-1];
    end
  end

  // axis weights
  for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
    tli_axis_weight u_axis (
      .clk    (clk),
      .offset (offset_arr[ax]),
      .inv    (inv_arr[ax]),
      .w      (aw[ax])
    );
  end

  assign axis_clip = aw[0].clip | aw[1].clip | aw[2].clip;

  // x-y pair weights
  tli_fx_mul u_pair_ll (
    .clk (clk), .a (aw[0].left), .b (MUL_B_W'(aw[1].left)),
    .clip_in (axis_clip), .res (pxy[0])
  );
  tli_fx_mul u_pair_lr (
    .clk (clk), .a (aw[0].left), .b (MUL_B_W'(aw[1].right)),
    .clip_in (axis_clip), .res (pxy[1])
  );
  tli_fx_mul u_pair_rl (
    .clk (clk), .a (aw[0].right), .b (MUL_B_W'(aw[1].left)),
    .clip_in (axis_clip), .res (pxy[2])
  );
  tli_fx_mul u_pair_rr (
    .clk (clk), .a (aw[0].right), .b (MUL_B_W'(aw[1].right)),
    .clip_in (axis_clip), .res (pxy[3])
  );

  // z weights wait for the pair products
  always_ff @(posedge clk) begin
    z_dly[0] <= aw[2];
    z_dly[1] <= z_dly[0];
  end

  // one lane per corner
  for (genvar cn = 0; cn < NUM_CORNERS; cn++) begin : g_lane
    tli_corner_lane u_lane (
      .clk    (clk),
      .pxy    (pxy[LANE_PAIR[cn]]),
      .w_z    (LANE_Z_RIGHT[cn] ? z_dly[Z_DLY-1].right : z_dly[Z_DLY-1].left),
      .corner (c_dly[CORNER_DLY-1][cn]),
      .prod   (lane_prod[cn]),
      .clip   (lane_clip[cn])
    );
  end

  // sum of the weighted corners
  tli_merge u_merge (
    .clk    (clk),
    .prod   (lane_prod),
    .clip   (lane_clip),
    .result (result)
  );

  assign interpolated_value = result.value;
  assign saturated          = result.clip;

endmodule

`default_nettype wire

// ===== rtl/core/tli_checker.sv =====
// port level checks on the interpolator timing, bound to the top level
`default_nettype none

module tli_checker
  import tli_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  // every transfer yields a result after the fixed latency
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_DEPTH done)
    else $error("transfer without result after pipeline latency");

  // no result without a transfer at the matching cycle
  a_no_orphan : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result strobe without matching transfer");

  // reset flushes the pipeline and holds off transfers
  a_reset_quiet : assert property (@(posedge clk)
    rst |=> (!done && busy))
    else $error("result or ready seen right after reset");

  // busy drops in the cycle after reset is released
  a_busy_release : assert property (@(posedge clk)
    ($past(rst, 2) && !$past(rst) && !rst) |-> !busy)
    else $error("busy held after reset settle cycle");

endmodule

bind trilinear_interpolator_core tli_checker u_tli_checker (.*);

`default_nettype wire
